// File: rtl/tsf_pkg.sv
// Shared types and constants for the turn signal flasher.
// Used by the controller, datapath, remainder unit and top level.
package tsf_pkg;

   // Lamp mode held between beats
   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_LEFT   = 2'd1,
      MODE_RIGHT  = 2'd2,
      MODE_HAZARD = 2'd3
   } mode_type;

   // Button event codes
   localparam logic [1:0] BTN_NONE  = 2'd0;
   localparam logic [1:0] BTN_LEFT  = 2'd1;
   localparam logic [1:0] BTN_RIGHT = 2'd2;
   localparam logic [1:0] BTN_LONG  = 2'd3;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_AUTO_OFF = 2'd0;
   localparam logic [1:0] CSR_PERIOD   = 2'd1;
   localparam logic [1:0] CSR_DUTY     = 2'd2;

   // Register reset values
   localparam logic [31:0] AUTO_OFF_RESET = 32'd60000;
   localparam logic [15:0] PERIOD_RESET   = 16'd667;
   localparam logic [6:0]  DUTY_RESET     = 7'd50;

   // Field widths
   localparam int TIME_W   = 32;
   localparam int PERIOD_W = 16;
   localparam int DUTY_W   = 7;
   localparam int PROD_W   = PERIOD_W + DUTY_W;

   // One remainder bit per step over the whole timestamp
   localparam int DIV_STEPS = TIME_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_FINISH
   } ctrl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;   // take the beat, update mode, seed the remainder
      logic step;   // one remainder iteration
      logic emit;   // write the lamp result register
   } dp_cmd_type;

endpackage

// File: rtl/turn_signal_flasher_fsm.sv
// Turn signal flasher: each request beat carries a button event and a
// millisecond timestamp, and yields one response beat with the left and
// right lamp drive. The mode (off, left, right, hazard) is updated on the
// cycle the beat is taken; the blink phase needs time_ms modulo the blink
// period, found by a restoring remainder unit at one bit per cycle.
// A beat passes from acceptance to response through a load, 32 remainder
// steps and a result register write that waits for a free response slot.
// A new request is taken while the previous response still waits.
// Depends on tsf_pkg, tsf_ctrl, tsf_dp, tsf_rem.
module turn_signal_flasher_fsm
   import tsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [1:0] button, [33:2] time_ms, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] left_lamp, [1] right_lamp, rest zero
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   dp_cmd_type cmd;
   logic       left_lamp;
   logic       right_lamp;

   tsf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   tsf_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .button     (req_tdata[1:0]),
      .time_ms    (req_tdata[TIME_W+1:2]),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .left_lamp  (left_lamp),
      .right_lamp (right_lamp)
   );

   assign rsp_tdata = {6'b0, right_lamp, left_lamp};

endmodule

// File: rtl/tsf_rem.sv
// Iterative remainder unit: time_ms mod blink period, one bit per step.
// Depends on tsf_pkg for widths.
module tsf_rem
   import tsf_pkg::*;
(
   input  logic                clock,
   input  logic                load,
   input  logic                step,
   input  logic [TIME_W-1:0]   dividend,
   input  logic [PERIOD_W-1:0] divisor,
   output logic [PERIOD_W-1:0] remainder
);

   logic [TIME_W-1:0]   quo_ff, quo_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [PERIOD_W:0]   trial;
   logic [PERIOD_W:0]   diff;

   // Shift in the next dividend bit and subtract where it fits
   always_comb begin
      trial  = {rem_ff, quo_ff[TIME_W-1]};
      diff   = trial - {1'b0, divisor};
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (load) begin
         quo_in = dividend;
         rem_in = '0;
      end else if (step) begin
         quo_in = {quo_ff[TIME_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[PERIOD_W-1:0];
         end else begin
            rem_in = trial[PERIOD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign remainder = rem_ff;

endmodule

// File: rtl/tsf_ctrl.sv
// Controller for the turn signal flasher: sequences load, remainder steps
// and result write, and owns both handshakes. Depends on tsf_pkg.
module tsf_ctrl
   import tsf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;
   logic             out_free;
   logic             last_step;

   assign out_free  = !valid_ff || rsp_tready;
   assign last_step = (cnt_ff == CNT_W'(DIV_STEPS - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (last_step) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_BUSY: begin
            cmd.step = 1'b1;
         end
         ST_FINISH: begin
            cmd.emit = out_free;
         end
         default: ;
      endcase
   end

   // Step counter and result valid
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.load) begin
         cnt_in = '0;
      end else if (cmd.step) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      valid_in = valid_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

// File: rtl/tsf_dp.sv
// Datapath for the turn signal flasher: config registers, mode and start
// time, blink phase compare and result register. Depends on tsf_pkg, tsf_rem.
module tsf_dp
   import tsf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   input  logic [1:0]          button,
   input  logic [TIME_W-1:0]   time_ms,
   input  logic                csr_we,
   input  logic [1:0]          csr_addr,
   input  logic [31:0]         csr_wdata,
   output logic                left_lamp,
   output logic                right_lamp
);

   logic [31:0]         auto_off_ff, auto_off_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [DUTY_W-1:0]   duty_ff, duty_in;
   mode_type            mode_ff, mode_in;
   logic [TIME_W-1:0]   start_ff, start_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                left_ff, left_in;
   logic                right_ff, right_in;
   logic [TIME_W-1:0]   elapsed;
   logic [PERIOD_W-1:0] phase;
   logic [PERIOD_W:0]   phase_inc;
   logic [PROD_W:0]     phase_x100;
   logic                lit;

   tsf_rem u_rem (
      .clock     (clock),
      .load      (cmd.load),
      .step      (cmd.step),
      .dividend  (time_ms),
      .divisor   (period_ff),
      .remainder (phase)
   );

   // Config writes
   always_comb begin
      auto_off_in = auto_off_ff;
      period_in   = period_ff;
      duty_in     = duty_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_AUTO_OFF: auto_off_in = csr_wdata;
            CSR_PERIOD:   period_in   = csr_wdata[PERIOD_W-1:0];
            CSR_DUTY:     duty_in     = csr_wdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   // Mode transition on the accepted beat
   assign elapsed = time_ms - start_ff;

   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      if (cmd.load) begin
         case (mode_ff)
            MODE_OFF: begin
               if (button == BTN_LEFT) begin
                  mode_in  = MODE_LEFT;
                  start_in = time_ms;
               end else if (button == BTN_RIGHT) begin
                  mode_in  = MODE_RIGHT;
                  start_in = time_ms;
               end else if (button == BTN_LONG) begin
                  mode_in = MODE_HAZARD;
               end
            end
            MODE_LEFT, MODE_RIGHT: begin
               if (button == BTN_LONG) begin
                  mode_in = MODE_HAZARD;
               end else if (button == BTN_NONE) begin
                  if (elapsed >= auto_off_ff) begin
                     mode_in = MODE_OFF;
                  end
               end else if ((button == BTN_LEFT) == (mode_ff == MODE_LEFT)) begin
                  // same side pressed again
                  mode_in = MODE_OFF;
               end else begin
                  // other side: swap and restart the timer
                  mode_in  = (mode_ff == MODE_LEFT) ? MODE_RIGHT : MODE_LEFT;
                  start_in = time_ms;
               end
            end
            default: begin
               if (button == BTN_LEFT || button == BTN_RIGHT) begin
                  mode_in = MODE_OFF;
               end
            end
         endcase
      end
   end

   // Lit span times one hundred; held over the remainder steps
   assign prod_in = cmd.load ? (PROD_W'(period_ff) * PROD_W'(duty_ff)) : prod_ff;

   // phase < floor(P*D/100) holds exactly when 100*(phase+1) <= P*D
   assign phase_inc  = {1'b0, phase} + (PERIOD_W+1)'(1);
   assign phase_x100 = ((PROD_W+1)'(phase_inc) << 6) + ((PROD_W+1)'(phase_inc) << 5)
                     + ((PROD_W+1)'(phase_inc) << 2);
   assign lit = (period_ff != '0) && (phase_x100 <= {1'b0, prod_ff});

   // Result register, written once the remainder is settled
   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      if (cmd.emit) begin
         left_in  = lit && (mode_ff == MODE_LEFT  || mode_ff == MODE_HAZARD);
         right_in = lit && (mode_ff == MODE_RIGHT || mode_ff == MODE_HAZARD);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_off_ff <= AUTO_OFF_RESET;
         period_ff   <= PERIOD_RESET;
         duty_ff     <= DUTY_RESET;
         mode_ff     <= MODE_OFF;
         start_ff    <= '0;
      end else begin
         auto_off_ff <= auto_off_in;
         period_ff   <= period_in;
         duty_ff     <= duty_in;
         mode_ff     <= mode_in;
         start_ff    <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   assign left_lamp  = left_ff;
   assign right_lamp = right_ff;

endmodule

// File: tb/flasher_checker.sv
// Checker for the turn signal flasher: watches the request, response and csr ports,
// predicts the lamp drive of every request beat and compares it with each response.
// Depends on tsf_pkg for the mode, button and register codes.
`timescale 1ns / 100ps

module flasher_checker
   import tsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // [1:0] button, [33:2] time_ms, rest zero
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [0] left_lamp, [1] right_lamp, rest zero
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata,
   output int          lamps_pending,
   output int          fault_total
);

   typedef struct packed {
      logic right;
      logic left;
   } lamp_pair_type;

   // Local copy of the settings and the mode state
   logic [31:0] cfg_auto_off = AUTO_OFF_RESET;
   logic [15:0] cfg_period   = PERIOD_RESET;
   logic [6:0]  cfg_duty     = DUTY_RESET;
   mode_type    lamp_mode    = MODE_OFF;
   logic [31:0] start_ms     = '0;

   lamp_pair_type lamps_due[$];
   int            faults    = 0;
   int            rsp_count = 0;

   assign fault_total = faults;

   task automatic report_fault(input string msg);
      $display("[%0t] lamp check: %s", $realtime, msg);
      faults++;
   endtask

   // Advance the mode by one event and work out the lamp drive at that time
   function automatic lamp_pair_type step_flasher(input logic [1:0]  btn,
                                                  input logic [31:0] now);
      logic [1:0]    own_btn;
      logic [1:0]    other_btn;
      mode_type      other_mode;
      logic [31:0]   elapsed;
      logic [31:0]   lit_ms;
      logic          lit;
      lamp_pair_type lamps;
      elapsed = now - start_ms;
      case (lamp_mode)
         MODE_OFF: begin
            if (btn == BTN_LEFT) begin
               lamp_mode = MODE_LEFT;
               start_ms  = now;
            end else if (btn == BTN_RIGHT) begin
               lamp_mode = MODE_RIGHT;
               start_ms  = now;
            end else if (btn == BTN_LONG) begin
               lamp_mode = MODE_HAZARD;
            end
         end
         MODE_LEFT, MODE_RIGHT: begin
            own_btn    = (lamp_mode == MODE_LEFT) ? BTN_LEFT : BTN_RIGHT;
            other_btn  = (lamp_mode == MODE_LEFT) ? BTN_RIGHT : BTN_LEFT;
            other_mode = (lamp_mode == MODE_LEFT) ? MODE_RIGHT : MODE_LEFT;
            if (btn == own_btn) begin
               lamp_mode = MODE_OFF;
            end else if (btn == other_btn) begin
               lamp_mode = other_mode;
               start_ms  = now;
            end else if (btn == BTN_LONG) begin
               lamp_mode = MODE_HAZARD;
            end else if (elapsed >= cfg_auto_off) begin
               // timeout is only looked at on a beat without an event
               lamp_mode = MODE_OFF;
            end
         end
         default: begin
            if (btn == BTN_LEFT || btn == BTN_RIGHT) lamp_mode = MODE_OFF;
         end
      endcase
      // Blink phase: lit while now mod period is below the lit share
      lit_ms = (32'(cfg_period) * 32'(cfg_duty)) / 32'd100;
      lit    = 1'b0;
      if (cfg_period != '0) lit = (now % 32'(cfg_period)) < lit_ms;
      lamps.left  = lit && (lamp_mode == MODE_LEFT || lamp_mode == MODE_HAZARD);
      lamps.right = lit && (lamp_mode == MODE_RIGHT || lamp_mode == MODE_HAZARD);
      return lamps;
   endfunction

   // Track settings, predict on request beats, compare on response beats
   always @(posedge clock) begin
      lamp_pair_type want;
      if (reset) begin
         cfg_auto_off = AUTO_OFF_RESET;
         cfg_period   = PERIOD_RESET;
         cfg_duty     = DUTY_RESET;
         lamp_mode    = MODE_OFF;
         start_ms     = '0;
         lamps_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_AUTO_OFF: cfg_auto_off = csr_wdata;
               CSR_PERIOD:   cfg_period   = csr_wdata[15:0];
               CSR_DUTY:     cfg_duty     = csr_wdata[6:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            lamps_due.push_back(step_flasher(req_tdata[1:0], req_tdata[33:2]));
         if (rsp_tvalid && rsp_tready) begin
            if (lamps_due.size() == 0) begin
               report_fault($sformatf("response beat %0d arrived with nothing expected",
                                      rsp_count));
            end else begin
               want = lamps_due.pop_front();
               if (rsp_tdata[0] !== want.left)
                  report_fault($sformatf("beat %0d left_lamp: expected %b, got %b",
                                         rsp_count, want.left, rsp_tdata[0]));
               if (rsp_tdata[1] !== want.right)
                  report_fault($sformatf("beat %0d right_lamp: expected %b, got %b",
                                         rsp_count, want.right, rsp_tdata[1]));
            end
            rsp_count++;
         end
      end
      lamps_pending <= lamps_due.size();
   end

endmodule

// File: tb/testbench.sv
// Top of the turn signal flasher testbench: clock, reset, settings and button beats,
// random gaps on both channels, and the final verdict.
// Depends on tsf_pkg, turn_signal_flasher_fsm and flasher_checker.
`timescale 1ns / 100ps

module testbench
   import tsf_pkg::*;
();

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // [1:0] button, [33:2] time_ms, rest zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [0] left_lamp, [1] right_lamp, rest zero
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = '0;
   logic [31:0] csr_wdata  = '0;

   int lamps_pending;
   int fault_total;
   bit calm = 1'b0;   // no gaps on either side while set

   turn_signal_flasher_fsm u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   flasher_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .lamps_pending (lamps_pending),
      .fault_total   (fault_total)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Give up well past the slowest correct run
   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   // Send one button beat after a random gap; returns at the edge that takes it
   task automatic send_beat(input logic [1:0] btn, input logic [31:0] now);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, now, btn};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and hold until every expected response has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (lamps_pending != 0) @(posedge clock);
   endtask

   // Write all three registers on consecutive edges
   task automatic load_settings(input logic [31:0] off_ms, input logic [15:0] period,
                                input logic [6:0] duty);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_AUTO_OFF;
      csr_wdata <= off_ms;
      @(posedge clock);
      csr_addr  <= CSR_PERIOD;
      csr_wdata <= 32'(period);
      @(posedge clock);
      csr_addr  <= CSR_DUTY;
      csr_wdata <= 32'(duty);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Response side: stall a random number of cycles before each beat
   initial begin
      int stall;
      forever begin
         stall = calm ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Stimulus
   initial begin
      logic [31:0] now_ms;
      logic [31:0] off_ms;
      logic [15:0] period;
      logic [6:0]  duty;
      logic [1:0]  btn;
      int          step_max;
      int          pick;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed walk through every transition under the reset settings
      send_beat(BTN_NONE, 32'd0);
      send_beat(BTN_LONG, 32'd1);              // off to hazard
      send_beat(BTN_LONG, 32'd2);              // hazard holds
      send_beat(BTN_RIGHT, 32'd3);             // short press leaves hazard
      send_beat(BTN_LEFT, 32'd100);
      send_beat(BTN_NONE, 32'd200);
      send_beat(BTN_LEFT, 32'd300);            // same side toggles off
      send_beat(BTN_RIGHT, 32'd400);
      send_beat(BTN_LEFT, 32'd500);            // switch sides, timer restarts
      send_beat(BTN_RIGHT, 32'd600);
      send_beat(BTN_LONG, 32'd700);            // side to hazard
      send_beat(BTN_LEFT, 32'd800);
      send_beat(BTN_RIGHT, 32'd1000);
      send_beat(BTN_NONE, 32'd61000);          // elapsed equals the timeout
      send_beat(BTN_LEFT, 32'hFFFF_FF00);
      send_beat(BTN_NONE, 32'd59743);          // wrapped elapsed one short
      send_beat(BTN_RIGHT, 32'd60000);         // timeout with an event
      send_beat(BTN_NONE, 32'hFFFF_FFFF);
      send_beat(BTN_LONG, 32'd0);
      send_beat(BTN_NONE, 32'h7FFF_FFFF);      // hazard never times out
      send_beat(BTN_NONE, 32'hAAAA_AAAA);
      send_beat(BTN_LEFT, 32'h5555_5555);
      now_ms = 32'h5555_5555;

      // Random phases, each under its own settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin off_ms = 32'hFFFF_FFFF; period = 16'hFFFF; duty = 7'd100; end
            1: begin off_ms = 32'd0;         period = 16'd0;    duty = 7'd127; end
            2: begin off_ms = 32'd1;         period = 16'd1;    duty = 7'd0;   end
            3: begin off_ms = 32'h8000_0000; period = 16'd7;    duty = 7'd127; end
            default: begin
               off_ms = $urandom_range(0, 3000);
               period = 16'($urandom_range(1, 1200));
               duty   = 7'($urandom_range(0, 110));
            end
         endcase
         step_max = (ph < 4) ? 300 : int'(off_ms) / 3 + 20;
         wait_drained();
         calm = (ph % 3 == 2);
         load_settings(off_ms, period, duty);

         // Widest timeout: elapsed of all ones still switches off
         if (ph == 0) begin
            send_beat(BTN_LONG, now_ms);
            send_beat(BTN_LEFT, now_ms);
            send_beat(BTN_LEFT, now_ms + 32'd5);
            send_beat(BTN_NONE, now_ms + 32'd4);
         end

         for (int n = 0; n < 100; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      btn = BTN_NONE;
            else if (pick < 80) btn = BTN_LEFT;
            else if (pick < 90) btn = BTN_RIGHT;
            else                btn = BTN_LONG;
            pick = $urandom_range(0, 99);
            if (pick < 88)      now_ms = now_ms + $urandom_range(0, step_max);
            else if (pick < 96) now_ms = $urandom();
            else                now_ms = now_ms - $urandom_range(1, 50);
            send_beat(btn, now_ms);
         end
      end

      // Drain and let the block settle
      wait_drained();
      calm = 1'b0;
      repeat (40) @(posedge clock);
      if (fault_total == 0 && lamps_pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// File: filelist.f
rtl/tsf_pkg.sv
rtl/tsf_rem.sv
rtl/tsf_ctrl.sv
rtl/tsf_dp.sv
rtl/turn_signal_flasher_fsm.sv
tb/flasher_checker.sv
tb/testbench.sv
